/* hdl/pfn_pkg.sv */
// pfn_pkg: shared types, widths and helpers for the fractal gradient noise pipeline.
// No dependencies.
package pfn_pkg;

  localparam int COORD_BITS = 16;
  localparam int FREQ_BITS  = 24;
  localparam int OCT_BITS   = 4;
  localparam int FRAC_BITS  = 16;
  localparam int TAB_BITS   = 8;
  localparam int TABLE_SIZE = 1 << TAB_BITS;
  localparam int SCL_W      = FRAC_BITS + TAB_BITS;
  localparam int DOT_W      = FRAC_BITS + 3;
  localparam int DIF_W      = DOT_W + 1;
  localparam int LRP_W      = FRAC_BITS + 4;
  localparam int FADE_W     = FRAC_BITS + 1;
  localparam int P_W        = FRAC_BITS + 4;
  localparam int Q_BITS     = FRAC_BITS + 2;
  localparam int NOISE_W    = 16;
  localparam int GRAY_W     = 8;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_OCTAVE_COUNT = 1'b0,
    REG_BASE_FREQ    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                valid;
    cmd_t                cmd;
    logic [SCL_W-1:0]    sx;
    logic [SCL_W-1:0]    sy;
    logic [TAB_BITS-1:0] tidx;
    logic [TAB_BITS-1:0] tval;
  } beat_t;

  typedef struct packed {
    logic valid;
    logic neg;
  } div_ctl_t;

  typedef struct packed {
    logic signed [NOISE_W-1:0] noise;
    logic [GRAY_W-1:0]         gray;
  } res_t;

  // round((noise + 1) / 2 * 255) on the Q1.15 code
  function automatic logic [GRAY_W-1:0] gray_of(logic signed [NOISE_W-1:0] nv);
    logic [NOISE_W-1:0] ofs;
    logic [24:0]        sc;
    ofs = {~nv[NOISE_W-1], nv[NOISE_W-2:0]};
    sc  = {1'b0, ofs, 8'b0} - {9'b0, ofs} + 25'd32768;
    return sc[23:16];
  endfunction

endpackage

/* hdl/pfn_octave_cell.sv */
// pfn_octave_cell: one octave of the noise chain, nine register stages.
// Holds its own copies of the permutation table; depends on pfn_pkg.
module pfn_octave_cell #(
  parameter int K     = 0,
  parameter int NW    = 4,
  parameter int ACC_W = 28
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic [NW-1:0]           n_eff,
  input  pfn_pkg::beat_t          b_in,
  input  logic signed [ACC_W-1:0] acc_in,
  output pfn_pkg::beat_t          b_out,
  output logic signed [ACC_W-1:0] acc_out
);
  import pfn_pkg::*;

  localparam int NST = 9;
  localparam logic [NW-1:0] KIDX = NW'(K);
  localparam logic signed [DOT_W-1:0] ONE_D = DOT_W'(1 << FRAC_BITS);
  localparam logic [P_W:0] TEN_ONE = (P_W+1)'(10 << FRAC_BITS);

  typedef enum logic [1:0] {
    GRAD_PP = 2'd0,
    GRAD_NP = 2'd1,
    GRAD_NN = 2'd2,
    GRAD_PN = 2'd3
  } grad_t;

  function automatic logic signed [DOT_W-1:0] grad(logic [1:0] h,
                                                   logic signed [DOT_W-1:0] dx,
                                                   logic signed [DOT_W-1:0] dy);
    unique case (grad_t'(h))
      GRAD_PP: return dx + dy;
      GRAD_NP: return dy - dx;
      GRAD_NN: return -dx - dy;
      GRAD_PN: return dx - dy;
      default: return dx + dy;
    endcase
  endfunction

  // 10 - 15t + 6t^2 in Q.FRAC_BITS
  function automatic logic [P_W-1:0] poly_p(logic [FRAC_BITS-1:0] t,
                                            logic [2*FRAC_BITS-1:0] sq);
    logic [2*FRAC_BITS+2:0] s6;
    logic [P_W:0]           sum;
    s6  = {1'b0, sq, 2'b00} + {2'b00, sq, 1'b0};
    sum = TEN_ONE - {1'b0, t, 4'b0} + {5'b0, t} + {2'b0, s6[2*FRAC_BITS+2:FRAC_BITS]};
    return sum[P_W-1:0];
  endfunction

  logic [TAB_BITS-1:0] mem_a [TABLE_SIZE];
  logic [TAB_BITS-1:0] mem_b [TABLE_SIZE];
  logic [TAB_BITS-1:0] mem_c [TABLE_SIZE];

  beat_t                   bs    [1:NST];
  logic signed [ACC_W-1:0] acc_s [1:NST];

  logic [SCL_W-1:0]    sx_in, sy_in;
  logic [TAB_BITS-1:0] cx_in;
  logic                wr;

  logic [TAB_BITS-1:0]  px0, px1, hbl, hbr, htl, htr, cy1;
  logic [TAB_BITS-1:0]  ha0, ha1, ha0p, ha1p;
  logic [FRAC_BITS-1:0] tx1, ty1, tx2, ty2, tx3, ty3;
  logic [2*FRAC_BITS-1:0] sqx2, sqy2, sqx_c, sqy_c, t3x_c, t3y_c;
  logic [P_W-1:0]       px3, py3, px4, py4;
  logic [FRAC_BITS-1:0] t2x3, t2y3, t3x4, t3y4;
  logic [2*FRAC_BITS+3:0] ux_c, vy_c;
  logic signed [DOT_W-1:0] fx0, fx1, fy0, fy1;
  logic signed [DOT_W-1:0] dbl3, dbr3, dtl3, dtr3, dbl4, dbr4, dbl5, dbr5;
  logic signed [DIF_W-1:0] dl4, dr4, dl5, dr5;
  logic [FADE_W-1:0]       u5, v5, u6, u7;
  logic signed [DIF_W+FADE_W:0]   pl1, pl2;
  logic signed [LRP_W-1:0]        i16, i26, i17, layer8;
  logic signed [LRP_W:0]          di7;
  logic signed [LRP_W+FADE_W+1:0] pm;

  assign sx_in = b_in.sx << K;
  assign sy_in = b_in.sy << K;
  assign cx_in = sx_in[SCL_W-1:FRAC_BITS];
  assign wr    = en && b_in.valid && (b_in.cmd == CMD_LOAD);

  assign ha0  = px0 + cy1;
  assign ha1  = px1 + cy1;
  assign ha0p = TAB_BITS'(px0 + cy1 + 1'b1);
  assign ha1p = TAB_BITS'(px1 + cy1 + 1'b1);

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_a[b_in.tidx] <= b_in.tval;
      mem_b[b_in.tidx] <= b_in.tval;
      mem_c[b_in.tidx] <= b_in.tval;
    end
    if (en) begin
      px0 <= mem_a[cx_in];
      px1 <= mem_a[TAB_BITS'(cx_in + 1'b1)];
      hbl <= mem_b[ha0];
      hbr <= mem_b[ha1];
      htl <= mem_c[ha0p];
      htr <= mem_c[ha1p];
    end
  end

  assign sqx_c = (2*FRAC_BITS)'(tx1) * (2*FRAC_BITS)'(tx1);
  assign sqy_c = (2*FRAC_BITS)'(ty1) * (2*FRAC_BITS)'(ty1);
  assign t3x_c = (2*FRAC_BITS)'(t2x3) * (2*FRAC_BITS)'(tx3);
  assign t3y_c = (2*FRAC_BITS)'(t2y3) * (2*FRAC_BITS)'(ty3);
  assign ux_c  = (2*FRAC_BITS+4)'(t3x4) * (2*FRAC_BITS+4)'(px4);
  assign vy_c  = (2*FRAC_BITS+4)'(t3y4) * (2*FRAC_BITS+4)'(py4);

  assign fx0 = $signed(DOT_W'(tx2));
  assign fy0 = $signed(DOT_W'(ty2));
  assign fx1 = fx0 - ONE_D;
  assign fy1 = fy0 - ONE_D;

  assign pl1 = dl5 * $signed({1'b0, v5});
  assign pl2 = dr5 * $signed({1'b0, v5});
  assign pm  = di7 * $signed({1'b0, u7});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= NST; s++) begin
        bs[s].valid <= 1'b0;
      end
    end else if (en) begin
      bs[1] <= b_in;
      for (int s = 2; s <= NST; s++) begin
        bs[s] <= bs[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_s[1] <= acc_in;
      for (int s = 2; s < NST; s++) begin
        acc_s[s] <= acc_s[s-1];
      end
      acc_s[NST] <= (KIDX < n_eff) ? (acc_s[NST-1] <<< 1) + ACC_W'(layer8)
                                   : acc_s[NST-1];
      // stage 1
      tx1 <= sx_in[FRAC_BITS-1:0];
      ty1 <= sy_in[FRAC_BITS-1:0];
      cy1 <= sy_in[SCL_W-1:FRAC_BITS];
      // stage 2
      tx2  <= tx1;
      ty2  <= ty1;
      sqx2 <= sqx_c;
      sqy2 <= sqy_c;
      // stage 3
      tx3  <= tx2;
      ty3  <= ty2;
      px3  <= poly_p(tx2, sqx2);
      py3  <= poly_p(ty2, sqy2);
      t2x3 <= sqx2[2*FRAC_BITS-1:FRAC_BITS];
      t2y3 <= sqy2[2*FRAC_BITS-1:FRAC_BITS];
      dbl3 <= grad(hbl[1:0], fx0, fy0);
      dbr3 <= grad(hbr[1:0], fx1, fy0);
      dtl3 <= grad(htl[1:0], fx0, fy1);
      dtr3 <= grad(htr[1:0], fx1, fy1);
      // stage 4
      px4  <= px3;
      py4  <= py3;
      t3x4 <= t3x_c[2*FRAC_BITS-1:FRAC_BITS];
      t3y4 <= t3y_c[2*FRAC_BITS-1:FRAC_BITS];
      dbl4 <= dbl3;
      dbr4 <= dbr3;
      dl4  <= DIF_W'(dtl3) - DIF_W'(dbl3);
      dr4  <= DIF_W'(dtr3) - DIF_W'(dbr3);
      // stage 5
      u5   <= ux_c[FRAC_BITS+FADE_W-1:FRAC_BITS];
      v5   <= vy_c[FRAC_BITS+FADE_W-1:FRAC_BITS];
      dbl5 <= dbl4;
      dbr5 <= dbr4;
      dl5  <= dl4;
      dr5  <= dr4;
      // stage 6
      u6  <= u5;
      i16 <= LRP_W'((pl1 >>> FRAC_BITS) + (DIF_W+FADE_W+1)'(dbl5));
      i26 <= LRP_W'((pl2 >>> FRAC_BITS) + (DIF_W+FADE_W+1)'(dbr5));
      // stage 7
      u7  <= u6;
      i17 <= i16;
      di7 <= (LRP_W+1)'(i26) - (LRP_W+1)'(i16);
      // stage 8
      layer8 <= LRP_W'((pm >>> FRAC_BITS) + (LRP_W+FADE_W+2)'(i17));
    end
  end

  assign b_out   = bs[NST];
  assign acc_out = acc_s[NST];

endmodule

/* hdl/pfn_div_cell.sv */
// pfn_div_cell: one restoring-division step, yields one quotient bit per beat.
// Depends on pfn_pkg.
module pfn_div_cell #(
  parameter int REM_W = 28,
  parameter int D_W   = 9,
  parameter int Q_W   = 18,
  parameter int BIT   = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [D_W-1:0]    d2,
  input  pfn_pkg::div_ctl_t ctl_in,
  input  logic [REM_W-1:0]  rem_in,
  input  logic [Q_W-1:0]    q_in,
  output pfn_pkg::div_ctl_t ctl_out,
  output logic [REM_W-1:0]  rem_out,
  output logic [Q_W-1:0]    q_out
);
  import pfn_pkg::*;

  logic [REM_W-1:0] sub;
  logic             ge;
  logic [Q_W-1:0]   q_next;

  assign sub = REM_W'(d2) << BIT;
  assign ge  = rem_in >= sub;

  always_comb begin
    q_next      = q_in;
    q_next[BIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? rem_in - sub : rem_in;
      q_out   <= q_next;
    end
  end

endmodule

/* hdl/perlin_fbm_noise_pixel.sv */
// Fractal 2-D gradient noise per pixel: front scale, chain of octave cells, divider chain.
// One beat per cycle while in_ready is high; it drops while the skid register holds a result.
// Each octave cell is nine stages; normalization is one stage per quotient bit (18).
// Reset clears all valids, sets octave_count to 1 and base_frequency to 4096.
// Table contents are undefined after reset until loaded. Depends on pfn_pkg.
module perlin_fbm_noise_pixel #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  pfn_pkg::reg_idx_t                   cfg_index,
  input  logic [pfn_pkg::FREQ_BITS-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [pfn_pkg::COORD_BITS-1:0]      x_coord,
  input  logic [pfn_pkg::COORD_BITS-1:0]      y_coord,
  input  logic [pfn_pkg::TAB_BITS-1:0]        table_index,
  input  logic [pfn_pkg::TAB_BITS-1:0]        table_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pfn_pkg::NOISE_W-1:0]  noise_value,
  output logic [pfn_pkg::GRAY_W-1:0]          gray_level
);
  import pfn_pkg::*;

  localparam int NW    = $clog2(MAX_OCTAVES + 1);
  localparam int ACC_W = LRP_W + MAX_OCTAVES;
  localparam int REM_W = ACC_W;
  localparam int D_W   = MAX_OCTAVES + 1;
  localparam int MUL_W = COORD_BITS + FREQ_BITS;

  logic [OCT_BITS-1:0]  octave_count;
  logic [FREQ_BITS-1:0] base_frequency;
  logic [NW-1:0]        n_eff;
  logic [MAX_OCTAVES:0] pow_n;
  logic [MAX_OCTAVES-1:0] d_val;
  logic [D_W-1:0]       d2;
  logic                 en;

  logic [MUL_W-1:0] mx, my;
  beat_t                   cb [0:MAX_OCTAVES];
  logic signed [ACC_W-1:0] ca [0:MAX_OCTAVES];

  div_ctl_t         dc   [0:Q_BITS];
  logic [REM_W-1:0] drem [0:Q_BITS];
  logic [Q_BITS-1:0] dq  [0:Q_BITS];
  logic signed [ACC_W-1:0] absv;

  logic                      fvalid;
  logic signed [NOISE_W-1:0] fnoise, nv_next;
  logic [Q_BITS-1:0]         qf;
  res_t fin_res, out_res, skid_res;
  logic skid_valid, leave_v;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count   <= OCT_BITS'(1);
      base_frequency <= FREQ_BITS'(4096);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OCTAVE_COUNT: octave_count   <= cfg_data[OCT_BITS-1:0];
        REG_BASE_FREQ:    base_frequency <= cfg_data;
        default:          octave_count   <= octave_count;
      endcase
    end
  end

  always_comb begin
    priority if (octave_count == '0) begin
      n_eff = NW'(1);
    end else if (32'(octave_count) > MAX_OCTAVES) begin
      n_eff = NW'(MAX_OCTAVES);
    end else begin
      n_eff = NW'(octave_count);
    end
  end

  assign pow_n = (MAX_OCTAVES+1)'(1) << n_eff;
  assign d_val = MAX_OCTAVES'(pow_n - (MAX_OCTAVES+1)'(1));
  assign d2    = {d_val, 1'b0};

  // flow control
  assign en       = !skid_valid;
  assign in_ready = en;

  // front stage: coordinate times base frequency
  assign mx = MUL_W'(x_coord) * MUL_W'(base_frequency);
  assign my = MUL_W'(y_coord) * MUL_W'(base_frequency);

  always_ff @(posedge clk) begin
    if (rst) begin
      cb[0].valid <= 1'b0;
    end else if (en) begin
      cb[0].valid <= in_valid;
      cb[0].cmd   <= cmd_t'(cmd);
      cb[0].sx    <= mx[SCL_W-1:0];
      cb[0].sy    <= my[SCL_W-1:0];
      cb[0].tidx  <= table_index;
      cb[0].tval  <= table_value;
    end
  end

  assign ca[0] = '0;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    pfn_octave_cell #(
      .K     (k),
      .NW    (NW),
      .ACC_W (ACC_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .n_eff   (n_eff),
      .b_in    (cb[k]),
      .acc_in  (ca[k]),
      .b_out   (cb[k+1]),
      .acc_out (ca[k+1])
    );
  end

  // normalize: q = floor((|sum| + d) / 2d)
  assign absv  = ca[MAX_OCTAVES][ACC_W-1] ? -ca[MAX_OCTAVES] : ca[MAX_OCTAVES];
  assign dq[0] = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dc[0].valid <= 1'b0;
    end else if (en) begin
      dc[0].valid <= cb[MAX_OCTAVES].valid && (cb[MAX_OCTAVES].cmd == CMD_PIXEL);
      dc[0].neg   <= ca[MAX_OCTAVES][ACC_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0] <= $unsigned(absv) + REM_W'(d_val);
    end
  end

  for (genvar j = 0; j < Q_BITS; j++) begin : g_div
    pfn_div_cell #(
      .REM_W (REM_W),
      .D_W   (D_W),
      .Q_W   (Q_BITS),
      .BIT   (Q_BITS - 1 - j)
    ) u_div (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .d2      (d2),
      .ctl_in  (dc[j]),
      .rem_in  (drem[j]),
      .q_in    (dq[j]),
      .ctl_out (dc[j+1]),
      .rem_out (drem[j+1]),
      .q_out   (dq[j+1])
    );
  end

  // signed saturate to Q1.15
  assign qf = dq[Q_BITS];

  always_comb begin
    if (dc[Q_BITS].neg) begin
      nv_next = (qf > Q_BITS'(32768)) ? NOISE_W'(16'h8000) : NOISE_W'(-qf);
    end else begin
      nv_next = (qf > Q_BITS'(32767)) ? NOISE_W'(16'h7FFF) : NOISE_W'(qf);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (en) begin
      fvalid <= dc[Q_BITS].valid;
      fnoise <= nv_next;
    end
  end

  assign fin_res.noise = fnoise;
  assign fin_res.gray  = gray_of(fnoise);
  assign leave_v       = fvalid && en;

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= leave_v;
      end
    end else if (leave_v) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (leave_v) begin
        out_res <= fin_res;
      end
    end else if (leave_v) begin
      skid_res <= fin_res;
    end
  end

  assign noise_value = out_res.noise;
  assign gray_level  = out_res.gray;

endmodule

/* hdl/pfn_checker.sv */
// pfn_checker: port-level assertions for perlin_fbm_noise_pixel, plus its bind.
// Depends on pfn_pkg.
module pfn_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [pfn_pkg::NOISE_W-1:0] noise_value,
  input logic [pfn_pkg::GRAY_W-1:0]         gray_level
);
  import pfn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(noise_value) && $stable(gray_level))
    else $error("output beat changed while stalled");

  a_gray: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gray_level == gray_of(noise_value))
    else $error("gray level does not match noise value");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind perlin_fbm_noise_pixel pfn_checker u_pfn_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .noise_value (noise_value),
  .gray_level  (gray_level)
);
